// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files of the text console engine.
// No dependencies; the macros sample on clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at the same edge.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the following edge.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/tcce_pkg.sv -----
// Package for the text console engine: field widths, character codes, modes,
// sequencer states and the result bundle. No dependencies.
package tcce_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // payload field widths
  localparam int MODE_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CELL_W  = 16;
  localparam int INDEX_W = 11;

  // control characters
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam int TAB_STEP = 4;

  // attribute after reset and the blank written on clear and scroll
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

  // APB register file: byte address bit 2 selects the register
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_CONSOLE_ATTR = 1'b0;

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_DRAIN,
    ST_FILL,
    ST_DONE
  } state_t;

  // result bundle from the sequencer to the output register
  typedef struct packed {
    logic [CELL_W-1:0]  cell_value;
    logic [COL_W-1:0]   cursor_column;
    logic [ROW_W-1:0]   cursor_row;
    logic [INDEX_W-1:0] cursor_index;
    logic               rejected;
  } res_t;

endpackage

// ----- hw/rtl/tcce_chan_if.sv -----
// Valid/ready channel interfaces for the text console engine.
// Depends on tcce_pkg for the payload field widths.

// input item channel
interface tcce_in_if;
  logic                          valid;
  logic                          ready;
  logic [tcce_pkg::MODE_W-1:0]   mode;
  logic [tcce_pkg::CHAR_W-1:0]   char_code;
  logic [tcce_pkg::ATTR_W-1:0]   cell_attribute;
  logic [tcce_pkg::COL_W-1:0]    column;
  logic [tcce_pkg::ROW_W-1:0]    row;

  modport source (output valid, mode, char_code, cell_attribute, column, row,
                  input ready);
  modport sink   (input valid, mode, char_code, cell_attribute, column, row,
                  output ready);
endinterface

// result channel
interface tcce_out_if;
  logic                           valid;
  logic                           ready;
  logic [tcce_pkg::CELL_W-1:0]    cell_value;
  logic [tcce_pkg::COL_W-1:0]     cursor_column;
  logic [tcce_pkg::ROW_W-1:0]     cursor_row;
  logic [tcce_pkg::INDEX_W-1:0]   cursor_index;
  logic                           rejected;

  modport source (output valid, cell_value, cursor_column, cursor_row, cursor_index,
                  rejected, input ready);
  modport sink   (input valid, cell_value, cursor_column, cursor_row, cursor_index,
                  rejected, output ready);
endinterface

// ----- hw/rtl/text_console_char_engine_top.sv -----
// Top level of the text console engine: sequencer, screen memory, APB register
// and output register. Depends on tcce_pkg, tcce_chan_if, assert_macros.svh.
//
// Usage:
//   in_chan takes one item per beat (mode, char_code, cell_attribute, column, row);
//   out_chan returns exactly one result beat per item, in order. The console
//   attribute is written over the APB port (psel/penable/pwrite/paddr/pwdata).
//   A put, direct write or no-op item runs through the EXEC and DONE states; its
//   result then loads into the output register and the next beat is taken in
//   IDLE. A read adds the READ state for the screen memory port.
//   A put that runs off the bottom row scrolls the screen through the memory's
//   read and write ports, one cell per cycle: SCROLL copies rows 2 to ROWS-1 up
//   one row, DRAIN writes the last copied cell and FILL blanks the bottom row.
//   After reset the CLEAR state sweeps every memory cell to blank, during which
//   in_chan.ready stays low; APB writes are taken as usual. The cursor resets
//   to row 1, column 0.
//   The output register holds a result while out_chan.ready is low; the next
//   item is still taken and worked, and its result waits in the sequencer
//   until the output register frees.
`include "assert_macros.svh"

module text_console_char_engine_top #(
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  tcce_in_if.sink                           in_chan,
  tcce_out_if.source                        out_chan,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tcce_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [tcce_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [tcce_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int DW    = tcce_pkg::CELL_W;
  localparam int IDX_W = tcce_pkg::INDEX_W;

  logic [tcce_pkg::ATTR_W-1:0] console_attr;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [DW-1:0]               mem_wdata;
  logic [AW-1:0]               mem_raddr;
  logic [DW-1:0]               mem_rdata;
  logic                        res_valid;
  logic                        res_ready;
  tcce_pkg::res_t              res;
  logic                        out_valid_r;
  tcce_pkg::res_t              out_res_r;
  logic                        in_beat;
  logic                        cursor_in_area;
  logic                        idx_ok;
  logic                        rej_clean;

  tcce_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .console_attr (console_attr)
  );

  tcce_screen_ram #(
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tcce_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .console_attr (console_attr),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // output register: loads when empty or being drained
  assign res_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.cell_value    = out_res_r.cell_value;
  assign out_chan.cursor_column = out_res_r.cursor_column;
  assign out_chan.cursor_row    = out_res_r.cursor_row;
  assign out_chan.cursor_index  = out_res_r.cursor_index;
  assign out_chan.rejected      = out_res_r.rejected;

  // terms for the checks below
  assign in_beat        = in_chan.valid && in_chan.ready;
  assign cursor_in_area = (out_chan.cursor_row != '0) && (int'(out_chan.cursor_row) < ROWS) &&
                          (int'(out_chan.cursor_column) < COLUMNS);
  assign idx_ok         = out_chan.cursor_index ==
                          IDX_W'(out_chan.cursor_row * COLUMNS + out_chan.cursor_column);
  assign rej_clean      = !out_chan.rejected || (out_chan.cell_value == '0);

  // one item in work at a time
  `ASSERT_NXT(a_one_in_work, in_beat, !in_chan.ready, "beat taken while an item is in work")
  // cursor stays on the text rows and inside the line
  `ASSERT_IMP(a_cursor_range, out_chan.valid, cursor_in_area, "cursor off the text area")
  // hardware cursor index agrees with row and column
  `ASSERT_IMP(a_cursor_index, out_chan.valid, idx_ok, "cursor index mismatch")
  // a refused access returns no cell data
  `ASSERT_IMP(a_reject_zero, out_chan.valid, rej_clean, "rejected beat carries cell data")

endmodule

// ----- hw/rtl/tcce_cfg.sv -----
// APB register block of the text console engine: holds the console attribute.
// Depends on tcce_pkg.
module tcce_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tcce_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [tcce_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [tcce_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [tcce_pkg::ATTR_W-1:0]       console_attr
);

  localparam int AW = tcce_pkg::APB_ADDR_W;
  localparam int DW = tcce_pkg::APB_DATA_W;
  localparam int TW = tcce_pkg::ATTR_W;

  logic [TW-1:0] attr_r;
  logic          wr_en;
  logic          sel_attr;

  // bit 2 of the byte address is the register index
  assign sel_attr = (paddr[AW-1] == tcce_pkg::REG_CONSOLE_ATTR);
  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tcce_pkg::ATTR_RESET;
    end else if (wr_en && sel_attr) begin
      attr_r <= pwdata[TW-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (sel_attr) begin
      prdata = {{(DW-TW){1'b0}}, attr_r};
    end
  end

  assign console_attr = attr_r;

endmodule

// ----- hw/rtl/tcce_screen_ram.sv -----
// Screen cell memory: one write port, one read port, registered read data.
// Depends on tcce_pkg for the cell width.
module tcce_screen_ram #(
  parameter  int DEPTH = tcce_pkg::COLUMNS_DEF * tcce_pkg::ROWS_DEF,
  localparam int AW    = $clog2(DEPTH),
  localparam int DW    = tcce_pkg::CELL_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] cells_mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      cells_mem[waddr] <= wdata;
    end
    rdata_r <= cells_mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/tcce_ctrl.sv -----
// Sequencer of the text console engine: cursor, put/write/read handling,
// clear after reset and the row-by-row scroll through the screen memory.
// Depends on tcce_pkg and tcce_in_if.
module tcce_ctrl #(
  parameter  int COLUMNS = tcce_pkg::COLUMNS_DEF,
  parameter  int ROWS    = tcce_pkg::ROWS_DEF,
  localparam int CELLS   = ROWS * COLUMNS,
  localparam int AW      = $clog2(CELLS),
  localparam int DW      = tcce_pkg::CELL_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tcce_in_if.sink                       in_chan,
  input  logic [tcce_pkg::ATTR_W-1:0]   console_attr,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [DW-1:0]                 mem_wdata,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [DW-1:0]                 mem_rdata,
  output logic                          res_valid,
  input  logic                          res_ready,
  output tcce_pkg::res_t                res
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int CSW   = CW + 1;
  localparam int RW    = $clog2(ROWS + 1);
  localparam int OCW   = tcce_pkg::COL_W;
  localparam int ORW   = tcce_pkg::ROW_W;
  localparam int OIW   = tcce_pkg::INDEX_W;
  localparam int CHW   = tcce_pkg::CHAR_W;
  localparam int TW    = tcce_pkg::ATTR_W;

  localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
  localparam logic [AW-1:0] SCROLL_FST  = AW'(COLUMNS);
  localparam logic [AW-1:0] SCROLL_LAST = AW'((ROWS - 1) * COLUMNS - 1);
  localparam logic [AW-1:0] FILL_FST    = AW'((ROWS - 1) * COLUMNS);

  tcce_pkg::state_t state_r, state_nxt;

  // latched item
  tcce_pkg::mode_t          mode_r;
  logic [CHW-1:0]           char_r;
  logic [TW-1:0]            attr_in_r;
  logic [OCW-1:0]           colin_r;
  logic [ORW-1:0]           rowin_r;

  // cursor and sweep state
  logic [CW-1:0]            col_r, col_nxt;
  logic [RW-1:0]            line_r, line_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic                     pend_r, pend_nxt;
  logic [AW-1:0]            pend_addr_r;
  logic [DW-1:0]            val_r, val_nxt;
  logic                     rej_r, rej_nxt;

  // put-mode decode
  logic [AW-1:0]            cur_addr;
  logic [AW-1:0]            dir_addr;
  logic                     put_we;
  logic [AW-1:0]            put_addr;
  logic [DW-1:0]            put_data;
  logic [CSW-1:0]           col_sum;
  logic [CW-1:0]            put_col;
  logic                     linc;
  logic [RW-1:0]            line_sum;
  logic                     do_scroll;
  logic                     dir_bad_wr;
  logic                     dir_bad_rd;

  assign cur_addr = AW'(line_r * COLUMNS + col_r);
  assign dir_addr = AW'(rowin_r * COLUMNS + colin_r);

  // position checks for direct write and read
  assign dir_bad_rd = (int'(rowin_r) >= ROWS) || (int'(colin_r) >= COLUMNS);
  assign dir_bad_wr = dir_bad_rd || (rowin_r == '0);

  // character interpretation and cursor advance
  always_comb begin
    put_we   = 1'b0;
    put_addr = cur_addr;
    put_data = {console_attr, char_r};
    col_sum  = {1'b0, col_r};
    linc     = 1'b0;
    case (char_r)
      tcce_pkg::CH_NEWLINE: begin
        col_sum = '0;
        linc    = 1'b1;
      end
      tcce_pkg::CH_RETURN: begin
        col_sum = '0;
      end
      tcce_pkg::CH_BACKSPACE: begin
        if (col_r != '0) begin
          col_sum  = {1'b0, col_r} - CSW'(1);
          put_we   = 1'b1;
          put_addr = cur_addr - AW'(1);
          put_data = {console_attr, tcce_pkg::CH_SPACE};
        end
      end
      tcce_pkg::CH_TAB: begin
        col_sum = {1'b0, col_r} + CSW'(tcce_pkg::TAB_STEP);
      end
      default: begin
        put_we  = 1'b1;
        col_sum = {1'b0, col_r} + CSW'(1);
      end
    endcase
    // wrap at the right edge
    if (col_sum >= CSW'(COLUMNS)) begin
      put_col = '0;
      linc    = 1'b1;
    end else begin
      put_col = col_sum[CW-1:0];
    end
    line_sum  = line_r + RW'(linc);
    do_scroll = (line_sum == RW'(ROWS));
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    col_nxt    = col_r;
    line_nxt   = line_r;
    pend_nxt   = 1'b0;
    val_nxt    = val_r;
    rej_nxt    = rej_r;
    mem_we     = 1'b0;
    mem_waddr  = pend_addr_r;
    mem_wdata  = mem_rdata;
    mem_raddr  = dir_addr;
    in_chan.ready = 1'b0;
    res_valid  = 1'b0;
    case (state_r)
      // blank every cell after reset
      tcce_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = tcce_pkg::BLANK_CELL;
        if (idx_r == LAST_CELL) begin
          idx_nxt   = '0;
          state_nxt = tcce_pkg::ST_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      tcce_pkg::ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          state_nxt = tcce_pkg::ST_EXEC;
        end
      end
      tcce_pkg::ST_EXEC: begin
        val_nxt   = '0;
        rej_nxt   = 1'b0;
        state_nxt = tcce_pkg::ST_DONE;
        case (mode_r)
          tcce_pkg::MODE_PUT: begin
            mem_we    = put_we;
            mem_waddr = put_addr;
            mem_wdata = put_data;
            col_nxt   = put_col;
            if (do_scroll) begin
              line_nxt  = RW'(ROWS - 1);
              idx_nxt   = SCROLL_FST;
              state_nxt = tcce_pkg::ST_SCROLL;
            end else begin
              line_nxt = line_sum;
            end
          end
          tcce_pkg::MODE_WRITE: begin
            if (dir_bad_wr) begin
              rej_nxt = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = dir_addr;
              mem_wdata = {attr_in_r, char_r};
            end
          end
          tcce_pkg::MODE_READ: begin
            if (dir_bad_rd) begin
              rej_nxt = 1'b1;
            end else begin
              state_nxt = tcce_pkg::ST_READ;
            end
          end
          default: begin
            state_nxt = tcce_pkg::ST_DONE;
          end
        endcase
      end
      // read data returns in the cycle after the address
      tcce_pkg::ST_READ: begin
        val_nxt   = mem_rdata;
        state_nxt = tcce_pkg::ST_DONE;
      end
      // copy each cell from the row below; each write comes in the cycle after its read
      tcce_pkg::ST_SCROLL: begin
        mem_raddr = idx_r + AW'(COLUMNS);
        mem_we    = pend_r;
        pend_nxt  = 1'b1;
        if (idx_r == SCROLL_LAST) begin
          state_nxt = tcce_pkg::ST_DRAIN;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      // last copied cell
      tcce_pkg::ST_DRAIN: begin
        mem_we    = 1'b1;
        idx_nxt   = FILL_FST;
        state_nxt = tcce_pkg::ST_FILL;
      end
      // blank the bottom row
      tcce_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = tcce_pkg::BLANK_CELL;
        if (idx_r == LAST_CELL) begin
          state_nxt = tcce_pkg::ST_DONE;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      tcce_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = tcce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tcce_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcce_pkg::ST_CLEAR;
      idx_r   <= '0;
      col_r   <= '0;
      line_r  <= RW'(1);
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      col_r   <= col_nxt;
      line_r  <= line_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // item latch and result payload
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      mode_r    <= tcce_pkg::mode_t'(in_chan.mode);
      char_r    <= in_chan.char_code;
      attr_in_r <= in_chan.cell_attribute;
      colin_r   <= in_chan.column;
      rowin_r   <= in_chan.row;
    end
    pend_addr_r <= idx_r;
    val_r       <= val_nxt;
    rej_r       <= rej_nxt;
  end

  assign res.cell_value    = val_r;
  assign res.cursor_column = OCW'(col_r);
  assign res.cursor_row    = ORW'(line_r);
  assign res.cursor_index  = OIW'(line_r * COLUMNS + col_r);
  assign res.rejected      = rej_r;

endmodule
